[rtl/core/binary_heap_priority_queue_core_macros.svh]
// Assertion macros shared by the heap queue modules.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH

// Checked at every rising edge while the block is out of reset.
`define BHPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define BHPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/core/bhpq_pkg.sv]
// Types, codes and the ordering function of the heap queue.
package bhpq_pkg;

  // Command codes of a request.
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  // Status codes of a response.
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Heap order selected by the mode register.
  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountOutWidth = 7;

  typedef logic signed [ValueWidth-1:0] value_t;

  typedef struct packed {
    cmd_e   command;
    value_t value;
  } in_req_t;

  typedef struct packed {
    status_e                  status;
    value_t                   removed_value;
    logic [CountOutWidth-1:0] entry_count;
  } out_rsp_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_READ,
    S_UP_CMP,
    S_RM_LOAD,
    S_DN_READ,
    S_DN_CMP,
    S_RESP
  } state_e;

  // True when x belongs strictly above y under the given mode.
  function automatic logic better(logic mode, value_t x, value_t y);
    logic res;
    if (mode == MODE_MIN) begin
      res = (x < y);
    end else begin
      res = (x > y);
    end
    return res;
  endfunction

endpackage

[rtl/core/bhpq_store.sv]
// Heap entry memory: one write port, two registered read ports.
module bhpq_store
  import bhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  value_t        wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output value_t        rdata_a_o,
  output value_t        rdata_b_o
);

  value_t mem_q [CAPACITY];

  // Write and read in the same clocked block; read data is ready next cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[rtl/core/bhpq_ctrl.sv]
// Sift sequencer of the heap queue, with fill count and response register.
`include "binary_heap_priority_queue_core_macros.svh"

module bhpq_ctrl
  import bhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          heap_mode_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_req_t       in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output out_rsp_t      out_data_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output value_t        mem_wdata_o,
  output logic [AW-1:0] mem_raddr_a_o,
  output logic [AW-1:0] mem_raddr_b_o,
  input  value_t        mem_rdata_a_i,
  input  value_t        mem_rdata_b_i
);

  localparam int unsigned IW = AW + 2;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] pos_q, pos_d;
  value_t        val_q, val_d;
  value_t        removed_q, removed_d;
  status_e       status_q, status_d;
  logic          out_valid_q, out_valid_d;
  out_rsp_t      out_data_q, out_data_d;

  logic          in_acc;
  logic [IW-1:0] lc, rc, n_ext;
  logic          lc_ok, rc_ok;
  logic          pick_r;
  value_t        pick_val;
  logic [AW-1:0] pick_addr;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Child slots of the current hole and their presence in the heap.
  assign lc = {1'b0, pos_q, 1'b1};
  assign rc = lc + IW'(1);
  assign n_ext = IW'(count_q);
  assign lc_ok = (lc < n_ext);
  assign rc_ok = (rc < n_ext);

  // Better child, a tie goes left.
  assign pick_r = rc_ok && better(heap_mode_i, mem_rdata_b_i, mem_rdata_a_i);
  assign pick_val = pick_r ? mem_rdata_b_i : mem_rdata_a_i;
  assign pick_addr = pick_r ? rc[AW-1:0] : lc[AW-1:0];

  // State, count and data registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    val_q      <= val_d;
    removed_q  <= removed_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
  end

  // Next state, memory accesses and response.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    pos_d         = pos_q;
    val_d         = val_q;
    removed_d     = removed_q;
    status_d      = status_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_data_d    = out_data_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = val_q;
    mem_raddr_a_o = '0;
    mem_raddr_b_o = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          removed_d = '0;
          status_d  = STATUS_DONE;
          if (in_data_i.command == CMD_INSERT) begin
            if (count_q >= CW'(CAPACITY)) begin
              status_d = STATUS_FULL;
              state_d  = S_RESP;
            end else begin
              pos_d   = count_q[AW-1:0];
              val_d   = in_data_i.value;
              count_d = count_q + CW'(1);
              state_d = S_UP_READ;
            end
          end else begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = S_RESP;
            end else begin
              // Fetch the root and the last entry together.
              mem_raddr_a_o = '0;
              mem_raddr_b_o = AW'(count_q - CW'(1));
              count_d       = count_q - CW'(1);
              state_d       = S_RM_LOAD;
            end
          end
        end
      end
      S_UP_READ: begin
        if (pos_q == '0) begin
          mem_we_o = 1'b1;
          state_d  = S_RESP;
        end else begin
          mem_raddr_a_o = (pos_q - AW'(1)) >> 1;
          state_d       = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we_o = 1'b1;
        if (better(heap_mode_i, val_q, mem_rdata_a_i)) begin
          // Parent moves down into the hole.
          mem_wdata_o = mem_rdata_a_i;
          pos_d       = (pos_q - AW'(1)) >> 1;
          state_d     = S_UP_READ;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RM_LOAD: begin
        removed_d = mem_rdata_a_i;
        val_d     = mem_rdata_b_i;
        pos_d     = '0;
        if (count_q == '0) begin
          state_d = S_RESP;
        end else begin
          state_d = S_DN_READ;
        end
      end
      S_DN_READ: begin
        if (!lc_ok) begin
          mem_we_o = 1'b1;
          state_d  = S_RESP;
        end else begin
          mem_raddr_a_o = lc[AW-1:0];
          mem_raddr_b_o = rc_ok ? rc[AW-1:0] : lc[AW-1:0];
          state_d       = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        mem_we_o = 1'b1;
        if (better(heap_mode_i, pick_val, val_q)) begin
          // Better child moves up into the hole.
          mem_wdata_o = pick_val;
          pos_d       = pick_addr;
          state_d     = S_DN_READ;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                = 1'b1;
          out_data_d.status          = status_q;
          out_data_d.removed_value   = removed_q;
          out_data_d.entry_count     = CountOutWidth'(count_q);
          state_d                    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BHPQ_ASSERT(count_in_range_a, count_q <= CW'(CAPACITY), "fill count above capacity")
  `BHPQ_ASSERT(write_in_heap_a, mem_we_o |-> (CW'(mem_waddr_o) < count_q), "write outside heap")
  `BHPQ_ASSERT(up_cmp_not_root_a, (state_q == S_UP_CMP) |-> (pos_q != '0), "sift up past root")
  `BHPQ_ASSERT(rsp_from_resp_a, $rose(out_valid_q) |-> $past(state_q == S_RESP), "stray response")

endmodule

[rtl/core/binary_heap_priority_queue_core.sv]
// Top level of the binary heap priority queue.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   request | in        | in_valid_i / in_stall_o | in_data_i (command, value)
//   result  | out       | out_valid_o/out_stall_i | out_data_o (status, value, count)
//   config  | in        | cfg_we_i                | cfg_wdata_i (heap_mode)
//
// An insert opens a hole at the end of the heap and sifts it up toward the root; a remove
// takes the root, moves the last entry into the hole and sifts it down; a refused request
// goes straight to the result. Each level the entry moves (at most log2 of CAPACITY) is a
// memory read and a compare and write.
// One request is worked at a time; the next is taken once the result is registered.
// The result register holds while out_stall_i is high; reset empties the heap.
`include "binary_heap_priority_queue_core_macros.svh"

module binary_heap_priority_queue_core
  import bhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_data_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic          heap_mode_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  value_t        mem_wdata;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  value_t        mem_rdata_a;
  value_t        mem_rdata_b;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_mode_q <= MODE_MAX;
    end else if (cfg_we_i) begin
      heap_mode_q <= cfg_wdata_i;
    end
  end

  bhpq_store #(
    .CAPACITY(CAPACITY),
    .AW      (AW)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr_a_i(mem_raddr_a),
    .raddr_b_i(mem_raddr_b),
    .rdata_a_o(mem_rdata_a),
    .rdata_b_o(mem_rdata_b)
  );

  bhpq_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .heap_mode_i  (heap_mode_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_a_o(mem_raddr_a),
    .mem_raddr_b_o(mem_raddr_b),
    .mem_rdata_a_i(mem_rdata_a),
    .mem_rdata_b_i(mem_rdata_b)
  );

  `BHPQ_ASSERT_ALWAYS(reset_mode_a, !rst_ni |=> rst_ni || (heap_mode_q == MODE_MAX), "mode not reset")

endmodule
